// ----- src/dtst_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtst_pkg
// Shared types and constants for the divider / timer / serial ticker.
// ----------------------------------------------------------------------------
package dtst_pkg;

   localparam int DIVIDER_WIDTH = 16;
   localparam int CMD_WIDTH     = 2;
   localparam int DATA_WIDTH    = 8;
   localparam int BITS_WIDTH    = 4;
   localparam int CSR_IDX_WIDTH = 2;
   localparam int RSP_FIELDS_W  = 3 + 2 * DATA_WIDTH;
   localparam int RSP_TDATA_W   = ((RSP_FIELDS_W + 7) / 8) * 8;

   // commands
   localparam logic [CMD_WIDTH-1:0] CMD_TICK      = 2'd0;
   localparam logic [CMD_WIDTH-1:0] CMD_SER_START = 2'd1;
   localparam logic [CMD_WIDTH-1:0] CMD_DIV_RESET = 2'd2;
   localparam logic [CMD_WIDTH-1:0] CMD_CNT_WRITE = 2'd3;

   // rate selects
   localparam logic [1:0] RATE_1024 = 2'd0;
   localparam logic [1:0] RATE_16   = 2'd1;
   localparam logic [1:0] RATE_64   = 2'd2;
   localparam logic [1:0] RATE_256  = 2'd3;

   // register indexes
   localparam logic [CSR_IDX_WIDTH-1:0] REG_TIMER_ENABLE = 2'd0;
   localparam logic [CSR_IDX_WIDTH-1:0] REG_RATE_SELECT  = 2'd1;
   localparam logic [CSR_IDX_WIDTH-1:0] REG_RELOAD_VALUE = 2'd2;
   localparam logic [CSR_IDX_WIDTH-1:0] REG_SERIAL_INT   = 2'd3;

   localparam logic [BITS_WIDTH-1:0] SERIAL_BITS = 4'd8;

   typedef struct packed {
      logic                  timer_enable;
      logic [1:0]            rate_select;
      logic [DATA_WIDTH-1:0] reload_value;
      logic                  serial_internal_clock;
   } cfg_type;

   typedef struct packed {
      logic [DATA_WIDTH-1:0] divider_high;
      logic [DATA_WIDTH-1:0] counter_value;
      logic                  joypad_poll;
      logic                  serial_irq;
      logic                  timer_irq;
   } result_type;

endpackage

// ----- src/divider_timer_serial_ticker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// divider_timer_serial_ticker
// Free-running divider with rate-selected 8-bit timer, modulo reload, serial
// bit countdown and joypad poll pulse.
//
// Usage:
//   req_*  : one transfer per command. tuser = command (0 tick, 1 start
//            serial, 2 reset divider, 3 write counter), tdata = write data.
//   rsp_*  : exactly one transfer per request, in order, carrying the
//            interrupt flags, the counter and the divider high byte.
//   csr_*  : register writes (0 enable, 1 rate, 2 reload, 3 internal clock);
//            always ready, to be written while no request is in flight.
//   A request passes one input register, then the state update and the result
//   register. Throughput is one request per cycle, set by the state update,
//   as long as the response is not stalled.
//   A stalled response holds its register; the input register still takes
//   one more request, after which req_tready drops until rsp_tready returns.
//   Synchronous reset clears all state, the config and both stages' valid flags.
// ----------------------------------------------------------------------------
module divider_timer_serial_ticker
   import dtst_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  logic [DATA_WIDTH-1:0]    req_tdata,   // [7:0] write_data
   input  logic [CMD_WIDTH-1:0]     req_tuser,   // [1:0] command
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   // [0] timer_irq, [1] serial_irq, [2] joypad_poll, [10:3] counter_value,
   // [18:11] divider_high, rest zero
   output logic [RSP_TDATA_W-1:0]   rsp_tdata,
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [CSR_IDX_WIDTH-1:0] csr_index,
   input  logic [DATA_WIDTH-1:0]    csr_data
);

   logic                  in_valid_ff, in_valid_in;
   logic [CMD_WIDTH-1:0]  in_cmd_ff;
   logic [DATA_WIDTH-1:0] in_data_ff;
   logic                  rsp_valid_ff, rsp_valid_in;
   result_type            rsp_ff;
   result_type            result;
   cfg_type               cfg;
   logic                  out_adv;
   logic                  commit;
   logic                  req_xfer;

   assign csr_ready = 1'b1;
   assign out_adv   = !rsp_valid_ff || rsp_tready;
   assign commit    = in_valid_ff && out_adv;
   assign req_tready = !in_valid_ff || out_adv;
   assign req_xfer  = req_tvalid && req_tready;

   assign in_valid_in  = req_xfer || (in_valid_ff && !out_adv);
   assign rsp_valid_in = commit || (rsp_valid_ff && !rsp_tready);

   dtst_regs u_regs (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   dtst_core u_core (
      .clock      (clock),
      .reset      (reset),
      .commit     (commit),
      .command    (in_cmd_ff),
      .write_data (in_data_ff),
      .cfg        (cfg),
      .result     (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         in_cmd_ff  <= req_tuser;
         in_data_ff <= req_tdata;
      end
      if (commit) begin
         rsp_ff <= result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_TDATA_W - RSP_FIELDS_W){1'b0}}, rsp_ff};

`ifndef SYNTH
   a_reload_on_irq: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.timer_irq |-> rsp_ff.counter_value == cfg.reload_value)
      else $error("timer irq without reload value in counter");

   a_rsp_from_input: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(in_valid_ff))
      else $error("response raised without a staged request");

   a_input_held: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !out_adv |=> in_valid_ff && $stable(in_cmd_ff) && $stable(in_data_ff))
      else $error("staged request lost while output stalled");
`endif

endmodule

// ----- src/dtst_regs.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtst_regs
// Configuration registers, written through the csr channel.
// ----------------------------------------------------------------------------
module dtst_regs
   import dtst_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_valid,
   input  logic [CSR_IDX_WIDTH-1:0] csr_index,
   input  logic [DATA_WIDTH-1:0]    csr_data,
   output cfg_type                  cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            REG_TIMER_ENABLE: cfg_in.timer_enable          = csr_data[0];
            REG_RATE_SELECT:  cfg_in.rate_select           = csr_data[1:0];
            REG_RELOAD_VALUE: cfg_in.reload_value          = csr_data;
            REG_SERIAL_INT:   cfg_in.serial_internal_clock = csr_data[0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ----- src/dtst_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtst_core
// Divider, counter and serial bit state with their update, registered on commit.
// ----------------------------------------------------------------------------
module dtst_core
   import dtst_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  commit,
   input  logic [CMD_WIDTH-1:0]  command,
   input  logic [DATA_WIDTH-1:0] write_data,
   input  cfg_type               cfg,
   output result_type            result
);

   logic [DIVIDER_WIDTH-1:0] divider_ff, divider_in;
   logic [DATA_WIDTH-1:0]    counter_ff, counter_in;
   logic                     active_ff, active_in;
   logic [BITS_WIDTH-1:0]    bits_ff, bits_in;

   logic [DIVIDER_WIDTH-1:0] div_inc;
   logic [DATA_WIDTH:0]      cnt_sum;
   logic [BITS_WIDTH-1:0]    bits_dec;
   logic                     rate_hit;
   logic                     tick;
   logic                     step;
   logic                     ser_edge;
   logic                     tirq;
   logic                     sirq;
   logic                     poll;

   assign div_inc  = divider_ff + 1'b1;
   assign cnt_sum  = {1'b0, counter_ff} + 1'b1;
   assign bits_dec = bits_ff - 1'b1;
   assign tick     = (command == CMD_TICK);

   always_comb begin
      unique case (cfg.rate_select)
         RATE_1024: rate_hit = (div_inc[9:0] == '0);
         RATE_16:   rate_hit = (div_inc[3:0] == '0);
         RATE_64:   rate_hit = (div_inc[5:0] == '0);
         RATE_256:  rate_hit = (div_inc[7:0] == '0);
         default:   rate_hit = 1'b0;
      endcase
   end

   assign step     = tick && cfg.timer_enable && rate_hit;
   assign ser_edge = tick && (div_inc[8:0] == '0) && active_ff && cfg.serial_internal_clock;
   assign tirq     = step && cnt_sum[DATA_WIDTH];
   assign sirq     = ser_edge && (bits_dec == '0);
   assign poll     = tick && (div_inc[11:0] == '0);

   always_comb begin
      divider_in = divider_ff;
      counter_in = counter_ff;
      active_in  = active_ff;
      bits_in    = bits_ff;
      unique case (command)
         CMD_TICK: begin
            divider_in = div_inc;
            if (step) begin
               counter_in = tirq ? cfg.reload_value : cnt_sum[DATA_WIDTH-1:0];
            end
            if (ser_edge) begin
               bits_in = bits_dec;
               if (sirq) begin
                  active_in = 1'b0;
               end
            end
         end
         CMD_SER_START: begin
            active_in = 1'b1;
            bits_in   = SERIAL_BITS;
         end
         CMD_DIV_RESET: divider_in = '0;
         CMD_CNT_WRITE: counter_in = write_data;
         default: divider_in = divider_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         divider_ff <= '0;
         counter_ff <= '0;
         active_ff  <= 1'b0;
         bits_ff    <= '0;
      end else if (commit) begin
         divider_ff <= divider_in;
         counter_ff <= counter_in;
         active_ff  <= active_in;
         bits_ff    <= bits_in;
      end
   end

   assign result.timer_irq     = tirq;
   assign result.serial_irq    = sirq;
   assign result.joypad_poll   = poll;
   assign result.counter_value = counter_in;
   assign result.divider_high  = divider_in[DIVIDER_WIDTH-1 -: DATA_WIDTH];

endmodule
